// ===== hw/rtl/hfps_pkg.sv =====
package hfps_pkg;

    // Store geometry
    localparam int MAX_PAGES = 32;
    localparam int MAX_SLOTS = 64;

    localparam int PAGE_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PCNT_W  = $clog2(MAX_PAGES + 1);
    localparam int KEY_AW  = PAGE_W + SLOT_W;
    localparam int KEY_DEPTH = 1 << KEY_AW;

    // Fixed field widths
    localparam int ACT_W      = 2;
    localparam int SIZE_W     = 16;
    localparam int KEY_W      = 32;
    localparam int KIND_W     = 2;
    localparam int OUT_PAGE_W = 5;
    localparam int OUT_SLOT_W = 6;
    localparam int CNT_W      = 7;
    localparam int NEED_W     = SIZE_W + 1;

    localparam int PAGE_HEADER = 16;
    localparam int SLOT_COST   = 4;
    localparam logic [SIZE_W-1:0] PAGE_LEN_RESET = 16'd4096;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_COUNT  = 2'd2
    } action_e;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_SEARCH  = 2'd1,
        KIND_PAGES   = 2'd2,
        KIND_RECORDS = 2'd3
    } kind_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_NEW,
        ST_SR_PT,
        ST_SR_PTW,
        ST_SR_KEY,
        ST_CNT_RD,
        ST_CNT_CAP,
        ST_RESULT
    } state_t;

    // One page table entry
    typedef struct packed {
        logic [SIZE_W-1:0] free;
        logic [CNT_W-1:0]  records;
    } pt_entry_t;

    localparam int PT_W = $bits(pt_entry_t);

    typedef struct packed {
        logic              rd_en;
        logic [PAGE_W-1:0] rd_addr;
        logic              wr_en;
        logic [PAGE_W-1:0] wr_addr;
        pt_entry_t         wr_data;
    } pt_req_t;

    typedef struct packed {
        logic              rd_en;
        logic [KEY_AW-1:0] rd_addr;
        logic              wr_en;
        logic [KEY_AW-1:0] wr_addr;
        logic [KEY_W-1:0]  wr_data;
    } key_req_t;

    // One result item
    typedef struct packed {
        kind_e                 kind;
        logic                  success;
        logic [OUT_PAGE_W-1:0] page;
        logic [OUT_SLOT_W-1:0] slot;
        logic [CNT_W-1:0]      count;
        logic                  last;
    } res_t;

endpackage

// ===== hw/rtl/hfps_ram.sv =====
module hfps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/hfps_engine.sv =====
module hfps_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hfps_pkg::SIZE_W-1:0]   page_len,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hfps_pkg::ACT_W-1:0]    s_action,
    input  logic [hfps_pkg::SIZE_W-1:0]   s_record_size,
    input  logic [hfps_pkg::KEY_W-1:0]    s_record_key,
    output logic                          m_valid,
    input  logic                          m_ready,
    output hfps_pkg::res_t                m_res,
    output hfps_pkg::pt_req_t             pt_req,
    input  hfps_pkg::pt_entry_t           pt_rd,
    output hfps_pkg::key_req_t            key_req,
    input  logic [hfps_pkg::KEY_W-1:0]    key_rd
);
    import hfps_pkg::*;

    state_t               state_reg, state_next;
    logic [PCNT_W-1:0]    pages_reg, pages_next;
    logic [PCNT_W-1:0]    p_reg, p_next;
    logic [NEED_W-1:0]    need_reg, need_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [CNT_W-1:0]     rec_reg, rec_next;
    logic [CNT_W-1:0]     slot_reg, slot_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [SLOT_W-1:0]    cmp_slot_reg, cmp_slot_next;
    res_t                 pend_reg, pend_next;
    res_t                 out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;

    logic [PCNT_W-1:0]    p_plus;
    logic [PAGE_W-1:0]    p_addr;
    logic [PAGE_W-1:0]    new_addr;
    logic                 last_page;
    logic                 fits_old;
    logic                 slots_full;
    logic [SIZE_W-1:0]    fresh;
    logic                 fits_new;
    logic                 table_full;
    logic                 hit;
    logic                 more_slots;
    logic                 out_free;
    logic                 accept;

    // Shared conditions
    assign p_plus     = p_reg + PCNT_W'(1);
    assign p_addr     = PAGE_W'(p_reg);
    assign new_addr   = PAGE_W'(pages_reg);
    assign last_page  = (p_plus == pages_reg);
    assign fits_old   = ({1'b0, pt_rd.free} >= need_reg);
    assign slots_full = (pt_rd.records >= CNT_W'(MAX_SLOTS));
    assign fresh      = (page_len > SIZE_W'(PAGE_HEADER)) ?
                        SIZE_W'(page_len - SIZE_W'(PAGE_HEADER)) : '0;
    assign fits_new   = ({1'b0, fresh} >= need_reg);
    assign table_full = (pages_reg >= PCNT_W'(MAX_PAGES));
    assign hit        = cmp_valid_reg && (key_rd == key_reg);
    assign more_slots = (slot_reg < rec_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign accept     = s_valid && (state_reg == ST_IDLE);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_res   = out_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_action)
                        ACT_INSERT: state_next = (pages_reg == '0) ? ST_INS_NEW : ST_INS_RD;
                        ACT_SEARCH: state_next = (pages_reg == '0) ? ST_RESULT : ST_SR_PT;
                        ACT_COUNT:  state_next = ST_RESULT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_RD:  state_next = ST_INS_CHK;
            ST_INS_CHK: begin
                if (fits_old) begin
                    state_next = ST_RESULT;
                end else if (last_page) begin
                    state_next = ST_INS_NEW;
                end else begin
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_NEW: state_next = ST_RESULT;
            ST_SR_PT:   state_next = ST_SR_PTW;
            ST_SR_PTW:  state_next = ST_SR_KEY;
            ST_SR_KEY: begin
                if (hit) begin
                    state_next = ST_RESULT;
                end else if (!more_slots) begin
                    state_next = last_page ? ST_RESULT : ST_SR_PT;
                end
            end
            ST_CNT_RD:  state_next = ST_CNT_CAP;
            ST_CNT_CAP: state_next = ST_RESULT;
            ST_RESULT: begin
                if (out_free) begin
                    state_next = pend_reg.last ? ST_IDLE : ST_CNT_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory requests
    always_comb begin
        pages_next     = pages_reg;
        p_next         = p_reg;
        need_next      = need_reg;
        key_next       = key_reg;
        rec_next       = rec_reg;
        slot_next      = slot_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_slot_next  = cmp_slot_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        pt_req         = '0;
        key_req        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    need_next = {1'b0, s_record_size} + NEED_W'(SLOT_COST);
                    key_next  = s_record_key;
                    p_next    = '0;
                    pend_next = '{kind: KIND_SEARCH, success: 1'b0, page: '0,
                                  slot: '0, count: '0, last: 1'b1};
                    if (s_action == ACT_COUNT) begin
                        pend_next.kind  = KIND_PAGES;
                        pend_next.count = CNT_W'(pages_reg);
                        pend_next.last  = (pages_reg == '0);
                    end
                end
            end
            ST_INS_RD: begin
                pt_req.rd_en   = 1'b1;
                pt_req.rd_addr = p_addr;
            end
            ST_INS_CHK: begin
                pend_next = '{kind: KIND_INSERT, success: 1'b0, page: '0,
                              slot: '0, count: '0, last: 1'b1};
                if (fits_old) begin
                    if (!slots_full) begin
                        key_req.wr_en   = 1'b1;
                        key_req.wr_addr = {p_addr, SLOT_W'(pt_rd.records)};
                        key_req.wr_data = key_reg;
                        pt_req.wr_en    = 1'b1;
                        pt_req.wr_addr  = p_addr;
                        pt_req.wr_data.free    = SIZE_W'({1'b0, pt_rd.free} - need_reg);
                        pt_req.wr_data.records = pt_rd.records + CNT_W'(1);
                        pend_next.success = 1'b1;
                    end
                end else if (!last_page) begin
                    p_next = p_plus;
                end
            end
            ST_INS_NEW: begin
                pend_next = '{kind: KIND_INSERT, success: 1'b0, page: '0,
                              slot: '0, count: '0, last: 1'b1};
                if (!table_full) begin
                    pages_next     = pages_reg + PCNT_W'(1);
                    pt_req.wr_en   = 1'b1;
                    pt_req.wr_addr = new_addr;
                    if (fits_new) begin
                        key_req.wr_en   = 1'b1;
                        key_req.wr_addr = {new_addr, SLOT_W'(0)};
                        key_req.wr_data = key_reg;
                        pt_req.wr_data.free    = SIZE_W'({1'b0, fresh} - need_reg);
                        pt_req.wr_data.records = CNT_W'(1);
                        pend_next.success = 1'b1;
                    end else begin
                        pt_req.wr_data.free    = fresh;
                        pt_req.wr_data.records = '0;
                    end
                end
            end
            ST_SR_PT: begin
                pt_req.rd_en   = 1'b1;
                pt_req.rd_addr = p_addr;
            end
            ST_SR_PTW: begin
                rec_next       = pt_rd.records;
                slot_next      = '0;
                cmp_valid_next = 1'b0;
            end
            ST_SR_KEY: begin
                // Issue one key read a cycle, compare the previous one
                cmp_valid_next = 1'b0;
                if (hit) begin
                    pend_next = '{kind: KIND_SEARCH, success: 1'b1,
                                  page: OUT_PAGE_W'(p_reg),
                                  slot: OUT_SLOT_W'(cmp_slot_reg),
                                  count: '0, last: 1'b1};
                end else if (more_slots) begin
                    key_req.rd_en   = 1'b1;
                    key_req.rd_addr = {p_addr, SLOT_W'(slot_reg)};
                    slot_next       = slot_reg + CNT_W'(1);
                    cmp_valid_next  = 1'b1;
                    cmp_slot_next   = SLOT_W'(slot_reg);
                end else if (last_page) begin
                    pend_next = '{kind: KIND_SEARCH, success: 1'b0, page: '0,
                                  slot: '0, count: '0, last: 1'b1};
                end else begin
                    p_next = p_plus;
                end
            end
            ST_CNT_RD: begin
                pt_req.rd_en   = 1'b1;
                pt_req.rd_addr = p_addr;
            end
            ST_CNT_CAP: begin
                pend_next = '{kind: KIND_RECORDS, success: 1'b0,
                              page: OUT_PAGE_W'(p_reg), slot: '0,
                              count: pt_rd.records, last: last_page};
                p_next = p_plus;
            end
            ST_RESULT: begin
                if (out_free) begin
                    out_next     = pend_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pages_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pages_reg     <= pages_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p_reg        <= p_next;
        need_reg     <= need_next;
        key_reg      <= key_next;
        rec_reg      <= rec_next;
        slot_reg     <= slot_next;
        cmp_slot_reg <= cmp_slot_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    a_pages_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pages_reg <= PCNT_W'(MAX_PAGES))
        else $error("open page count beyond page table size");

    a_key_wr_with_pt: assert property (@(posedge aclk) disable iff (!aresetn)
        key_req.wr_en |-> pt_req.wr_en)
        else $error("key stored without page table update");

    a_wr_then_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pt_req.wr_en |=> state_reg == ST_RESULT)
        else $error("page table write not followed by result");

    a_cmp_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> $past(key_req.rd_en))
        else $error("key compare without a preceding read");

endmodule

// ===== hw/rtl/heap_file_page_store.sv =====
// Operation: insert reads page entries in turn and tries to store the key in the first page
//   with room, or opens a new page; search reads each open page's entry and compares its keys;
//   count gives the page count, then each page's records. A stalled result is held.
// Throughput: one request at a time; a full search is bound by the single read port of
//   the key memory (one key read per cycle).
// Reset: synchronous, active low; clears page count, FSM and output valid, and sets
//   the page length to 4096. Memories are not cleared; only written entries are read.
module heap_file_page_store (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [hfps_pkg::SIZE_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [hfps_pkg::ACT_W-1:0]     s_action,
    input  logic [hfps_pkg::SIZE_W-1:0]    s_record_size,
    input  logic signed [hfps_pkg::KEY_W-1:0] s_record_key,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hfps_pkg::KIND_W-1:0]    m_result_kind,
    output logic                           m_success,
    output logic [hfps_pkg::OUT_PAGE_W-1:0] m_page_index,
    output logic [hfps_pkg::OUT_SLOT_W-1:0] m_slot_index,
    output logic [hfps_pkg::CNT_W-1:0]     m_count,
    output logic                           m_last
);
    import hfps_pkg::*;

    logic [SIZE_W-1:0] page_len_reg;
    res_t              res;
    pt_req_t           pt_req;
    key_req_t          key_req;
    logic [PT_W-1:0]   pt_rd_raw;
    pt_entry_t         pt_rd;
    logic [KEY_W-1:0]  key_rd;

    // Hold page length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_len_reg <= PAGE_LEN_RESET;
        end else if (cfg_we) begin
            page_len_reg <= cfg_wdata;
        end
    end

    hfps_ram #(
        .WIDTH (PT_W),
        .DEPTH (MAX_PAGES)
    ) u_page_table (
        .aclk    (aclk),
        .wr_en   (pt_req.wr_en),
        .wr_addr (pt_req.wr_addr),
        .wr_data (pt_req.wr_data),
        .rd_en   (pt_req.rd_en),
        .rd_addr (pt_req.rd_addr),
        .rd_data (pt_rd_raw)
    );

    assign pt_rd = pt_entry_t'(pt_rd_raw);

    hfps_ram #(
        .WIDTH (KEY_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_store (
        .aclk    (aclk),
        .wr_en   (key_req.wr_en),
        .wr_addr (key_req.wr_addr),
        .wr_data (key_req.wr_data),
        .rd_en   (key_req.rd_en),
        .rd_addr (key_req.rd_addr),
        .rd_data (key_rd)
    );

    hfps_engine u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .page_len      (page_len_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_record_size (s_record_size),
        .s_record_key  (s_record_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_res         (res),
        .pt_req        (pt_req),
        .pt_rd         (pt_rd),
        .key_req       (key_req),
        .key_rd        (key_rd)
    );

    // Unpack result fields
    assign m_result_kind = res.kind;
    assign m_success     = res.success;
    assign m_page_index  = res.page;
    assign m_slot_index  = res.slot;
    assign m_count       = res.count;
    assign m_last        = res.last;

endmodule
